/* hdl/sfm_pkg.sv */
// Shared types and constants for the substring find-all matcher.
`timescale 1ns / 1ps

package sfm_pkg;

    // Configuration port geometry: 64-bit registers at byte addresses 0, 8 and 16.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;

    // Register index, taken from paddr[4:3].
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd1;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd2;

    // Pattern length register width.
    localparam int LEN_REG_W = 5;

    // Result kinds.
    localparam logic RESULT_MATCH   = 1'b0;
    localparam logic RESULT_SUMMARY = 1'b1;

    // Match counter width and its saturation value.
    localparam int          COUNT_W   = 32;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Result queue depth; an accepted byte can push up to two results.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One input transfer.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic        result_kind;
        logic [31:0] match_position;
        logic [31:0] match_count;
        logic        overflow;
        logic        end_of_run;
    } out_item_t;

    // Push request into the result queue.
    typedef struct packed {
        logic      push_first;
        logic      push_second;
        out_item_t first_item;
        out_item_t second_item;
    } queue_push_t;

endpackage

/* hdl/sfm_result_queue.sv */
// Result queue that takes up to two results per cycle and delivers one per transfer.
`timescale 1ns / 1ps

module sfm_result_queue
    import sfm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  queue_push_t push,
    output logic        room_for_two,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data
);

    out_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QPTR_W-1:0]   second_ptr;
    logic                pop;
    logic [QCNT_W-1:0]   push_num;

    // Occupancy and transfer conditions.
    assign out_valid    = (count_reg != '0);
    assign out_data     = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    assign room_for_two = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Pointer and count updates.
    always_comb
    begin
        push_num    = QCNT_W'(push.push_first) + QCNT_W'(push.push_second);
        second_ptr  = wr_ptr_reg + QPTR_W'(1);
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_num);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_num - QCNT_W'(pop);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; the second result goes into the slot after the first.
    always_ff @(posedge clk)
    begin
        if (push.push_first)
        begin
            entry_reg[wr_ptr_reg] <= push.first_item;
        end
        if (push.push_second)
        begin
            entry_reg[second_ptr] <= push.second_item;
        end
    end

endmodule

/* hdl/substring_find_all_matcher_top.sv */
// Top level of the streaming substring matcher: configuration, window compare and text state.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid / in_stall   in_data  (text_byte, text_last)
//   out       output     out_valid / out_stall out_data (result fields)
//   config    input      APB psel / penable    paddr, pwdata, prdata
//
// One text byte is taken every cycle while in_stall is low; its results are written into the
// result queue at the accepting edge and can leave on the output in the following cycle.
// A byte that yields both a match report and a summary needs two output transfers.
// in_stall rises when the four-entry result queue has fewer than two free entries.
// Reset loads pattern length 1 and zero pattern bytes and clears the fill, position, count and overflow state.
// A stall on the output holds the front result; input keeps flowing until the queue has fewer than two free entries.
`timescale 1ns / 1ps

module substring_find_all_matcher_top
    import sfm_pkg::*;
#(
    parameter int PATTERN_MAX   = 16,
    parameter int POSITION_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Configuration registers.
    logic [LEN_REG_W-1:0]     length_reg;
    logic [63:0]              pat_low_reg;
    logic [63:0]              pat_high_reg;
    logic                     cfg_write;
    logic [1:0]               cfg_index;

    // Per-text state.
    logic [7:0]               win_reg [PATTERN_MAX];
    logic [7:0]               win_next [PATTERN_MAX];
    logic [PLEN_W-1:0]        fill_reg;
    logic [PLEN_W-1:0]        fill_next;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     sat_reg;
    logic                     sat_next;

    // Compare path.
    logic [7:0]               pat16 [16];
    logic [7:0]               pat [PATTERN_MAX];
    logic [PLEN_W-1:0]        plen;
    logic [PLEN_W-1:0]        plen_m1;
    logic [PLEN_W-1:0]        fill_step;
    logic [IDX_W-1:0]         pidx;
    logic                     all_equal;
    logic                     hit;
    logic                     pos_at_max;
    logic                     count_step_sat;
    logic [POSITION_BITS-1:0] start_pos;
    logic [POSITION_BITS+31:0] start_ext;
    logic [COUNT_W-1:0]       count_step;
    logic                     sat_step;

    // Handshake.
    logic                     accept;
    logic                     room_for_two;
    queue_push_t              push;
    out_item_t                match_item;
    out_item_t                summary_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:3];
    assign in_stall  = !room_for_two;
    assign accept    = in_valid && !in_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= LEN_REG_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: length_reg   <= pwdata[LEN_REG_W-1:0];
                REG_PATTERN_LOW:    pat_low_reg  <= pwdata;
                REG_PATTERN_HIGH:   pat_high_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    // Configuration reads.
    always_comb
    begin
        unique case (cfg_index)
            REG_PATTERN_LENGTH: prdata = CFG_DATA_W'(length_reg);
            REG_PATTERN_LOW:    prdata = pat_low_reg;
            REG_PATTERN_HIGH:   prdata = pat_high_reg;
            default:            prdata = '0;
        endcase
    end

    // Pattern bytes; bytes past the two registers read as zero.
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            pat16[j]     = pat_low_reg[8*j +: 8];
            pat16[j + 8] = pat_high_reg[8*j +: 8];
        end
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pat[j] = (j < 16) ? pat16[j % 16] : 8'h00;
        end
    end

    // Effective pattern length: zero counts as one, and it is capped at the window size.
    always_comb
    begin
        if (length_reg == '0)
        begin
            plen = PLEN_W'(1);
        end
        else if (32'(length_reg) > PATTERN_MAX)
        begin
            plen = PLEN_W'(PATTERN_MAX);
        end
        else
        begin
            plen = PLEN_W'(length_reg);
        end
        plen_m1 = plen - PLEN_W'(1);
    end

    // Shifted window and parallel compare: window entry k lines up with pattern byte plen-1-k.
    always_comb
    begin
        win_next[0] = in_data.text_byte;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            win_next[k] = win_reg[k - 1];
        end
        all_equal = 1'b1;
        pidx      = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pidx = IDX_W'(plen_m1 - PLEN_W'(k));
            if ((plen > PLEN_W'(k)) && (win_next[k] != pat[pidx]))
            begin
                all_equal = 1'b0;
            end
        end
        fill_step = (fill_reg == PLEN_W'(PATTERN_MAX)) ? fill_reg : fill_reg + PLEN_W'(1);
        hit       = (fill_step >= plen) && all_equal;
    end

    // Position, count and overflow updates for the byte being taken.
    always_comb
    begin
        pos_at_max     = &pos_reg;
        count_step_sat = hit && (count_reg == COUNT_MAX);
        sat_step       = sat_reg || pos_at_max || count_step_sat;
        count_step     = (hit && !count_step_sat) ? count_reg + COUNT_W'(1) : count_reg;
        if (pos_reg >= POSITION_BITS'(plen_m1))
        begin
            start_pos = pos_reg - POSITION_BITS'(plen_m1);
        end
        else
        begin
            start_pos = '0;
        end
        start_ext = {32'b0, start_pos};
    end

    // Result items.
    always_comb
    begin
        match_item.result_kind    = RESULT_MATCH;
        match_item.match_position = start_ext[31:0];
        match_item.match_count    = count_step;
        match_item.overflow       = sat_step;
        match_item.end_of_run     = !in_data.text_last;

        summary_item.result_kind    = RESULT_SUMMARY;
        summary_item.match_position = '0;
        summary_item.match_count    = count_step;
        summary_item.overflow       = sat_step;
        summary_item.end_of_run     = 1'b1;

        push.push_first  = accept && (hit || in_data.text_last);
        push.push_second = accept && hit && in_data.text_last;
        push.first_item  = hit ? match_item : summary_item;
        push.second_item = summary_item;
    end

    // Next text state; the last byte clears it for the next text.
    always_comb
    begin
        fill_next  = fill_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        sat_next   = sat_reg;
        if (accept)
        begin
            if (in_data.text_last)
            begin
                fill_next  = '0;
                pos_next   = '0;
                count_next = '0;
                sat_next   = 1'b0;
            end
            else
            begin
                fill_next  = fill_step;
                pos_next   = pos_at_max ? pos_reg : pos_reg + POSITION_BITS'(1);
                count_next = count_step;
                sat_next   = sat_step;
            end
        end
    end

    // Text state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            sat_reg   <= sat_next;
        end
    end

    // Byte window; the fill count masks stale bytes, so it needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // Result queue toward the output channel.
    sfm_result_queue u_result_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

endmodule
